@@ hdl/lbe_pkg.sv @@
`timescale 1ns / 1ps
// Package for the life board engine: board size, action codes and controller states.
// No dependencies; imported by life_board_engine.
package lbe_pkg;

  localparam int BOARD_SIDE = 64;
  localparam int ADDR_W     = (BOARD_SIDE > 1) ? $clog2(BOARD_SIDE) : 1;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int ACT_W      = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_GEN_PRIME,
    ST_GEN_RUN
  } state_t;

  typedef logic [BOARD_SIDE-1:0] board_row_t;

endpackage

@@ hdl/life_board_engine.sv @@
`timescale 1ns / 1ps
// Life board engine: B3/S23 board held in a row-wide synchronous RAM.
// Depends on lbe_pkg for board size, action codes and states.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------
//   input    | start, busy        | in_action, in_row, in_column
//   result   | out_strobe (pulse) | out_cell_alive
//
// Set, clear and read start with one RAM read; set and clear then modify the row and write it back.
// A generation writes one row per cycle,
// paced by the single RAM read port, with a one-row look-ahead read.
// Reset clears per-row valid bits, so every row reads as dead; no clearing pass.
// The receiver cannot stall: each result shows for one cycle after its item.
module life_board_engine
  import lbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [ACT_W-1:0] in_action,
  input  logic [ROW_W-1:0] in_row,
  input  logic [COL_W-1:0] in_column,
  output logic             out_strobe,
  output logic             out_cell_alive
);

  localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(BOARD_SIDE - 1);

  state_t             state_r, state_nxt;
  action_t            action_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   column_r;
  logic [ADDR_W-1:0]  wr_idx_r, wr_idx_nxt;
  board_row_t         above_r, above_nxt;
  board_row_t         here_r, here_nxt;
  logic               cap_r, cap_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  logic               out_cell_r, out_cell_nxt;

  board_row_t         mem [BOARD_SIDE];
  board_row_t         valid_r;
  board_row_t         mem_q;
  logic               rd_valid_r;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  board_row_t         wr_data;

  logic               accept;
  logic               on_board;
  logic [ADDR_W-1:0]  row_idx;
  logic [ADDR_W-1:0]  col_idx;
  board_row_t         q_eff;
  board_row_t         below;
  board_row_t         gen_row;
  board_row_t         cell_row;
  logic [ADDR_W:0]    ahead_idx;

  function automatic board_row_t next_gen(board_row_t a, board_row_t h, board_row_t b);
    logic [BOARD_SIDE+1:0] pa;
    logic [BOARD_SIDE+1:0] ph;
    logic [BOARD_SIDE+1:0] pb;
    logic [3:0]            n;
    board_row_t            res;
    pa = {1'b0, a, 1'b0};
    ph = {1'b0, h, 1'b0};
    pb = {1'b0, b, 1'b0};
    for (int c = 0; c < BOARD_SIDE; c++) begin
      n = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2]) + 4'(ph[c]) + 4'(ph[c+2])
        + 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
      res[c] = (n == 4'd3) || (h[c] && (n == 4'd2));
    end
    return res;
  endfunction

  assign accept   = start && (state_r == ST_IDLE);
  assign on_board = (32'(row_r) < BOARD_SIDE) && (32'(column_r) < BOARD_SIDE);
  assign row_idx  = ADDR_W'(row_r);
  assign col_idx  = ADDR_W'(column_r);
  assign q_eff    = rd_valid_r ? mem_q : '0;
  assign below    = (wr_idx_r == LAST_ROW) ? '0 : q_eff;
  assign gen_row  = next_gen(above_r, here_r, below);
  assign ahead_idx = {1'b0, wr_idx_r} + (ADDR_W+1)'(2);

  always_comb begin
    cell_row = q_eff;
    cell_row[col_idx] = (action_r == ACT_SET);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (action_t'(in_action) == ACT_STEP) ? ST_GEN_PRIME : ST_CELL;
        end
      end
      ST_CELL:      state_nxt = ST_IDLE;
      ST_GEN_PRIME: state_nxt = ST_GEN_RUN;
      ST_GEN_RUN: begin
        if (wr_idx_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    busy           = (state_r != ST_IDLE);
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = wr_idx_r;
    wr_data        = gen_row;
    wr_idx_nxt     = wr_idx_r;
    above_nxt      = above_r;
    here_nxt       = here_r;
    cap_nxt        = cap_r;
    out_strobe_nxt = 1'b0;
    out_cell_nxt   = out_cell_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          rd_en   = 1'b1;
          rd_addr = (action_t'(in_action) == ACT_STEP) ? '0 : ADDR_W'(in_row);
        end
      end
      ST_CELL: begin
        wr_addr        = row_idx;
        wr_data        = cell_row;
        wr_en          = on_board && ((action_r == ACT_SET) || (action_r == ACT_CLEAR));
        out_strobe_nxt = 1'b1;
        out_cell_nxt   = on_board && (((action_r == ACT_SET) || (action_r == ACT_CLEAR))
                         ? (action_r == ACT_SET) : q_eff[col_idx]);
      end
      ST_GEN_PRIME: begin
        above_nxt  = '0;
        here_nxt   = q_eff;
        wr_idx_nxt = '0;
        cap_nxt    = 1'b0;
        rd_en      = 1'b1;
        rd_addr    = ADDR_W'(1);
      end
      ST_GEN_RUN: begin
        wr_en     = 1'b1;
        above_nxt = here_r;
        here_nxt  = below;
        if (32'(ahead_idx) < BOARD_SIDE) begin
          rd_en   = 1'b1;
          rd_addr = ahead_idx[ADDR_W-1:0];
        end
        if (wr_idx_r == row_idx) begin
          cap_nxt = gen_row[col_idx];
        end
        if (wr_idx_r == LAST_ROW) begin
          out_strobe_nxt = 1'b1;
          out_cell_nxt   = on_board && ((wr_idx_r == row_idx) ? gen_row[col_idx] : cap_r);
        end else begin
          wr_idx_nxt = wr_idx_r + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      rd_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= action_t'(in_action);
      row_r    <= in_row;
      column_r <= in_column;
    end
    wr_idx_r   <= wr_idx_nxt;
    above_r    <= above_nxt;
    here_r     <= here_nxt;
    cap_r      <= cap_nxt;
    out_cell_r <= out_cell_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_cell_alive = out_cell_r;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for life_board_engine: a directed table of cell actions, then random pattern
// building and generation steps, every result checked against a board predictor or a fixed table value.
// Depends on lbe_pkg and life_board_engine.
module testbench;
  import lbe_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int PROBE_ROWS   = 25;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    action_t          act;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    bit               fixed;
    logic             alive;
  } cell_probe_t;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             start          = 1'b0;
  logic             busy;
  logic [ACT_W-1:0] in_action      = ACT_READ;
  logic [ROW_W-1:0] in_row         = '0;
  logic [COL_W-1:0] in_column      = '0;
  logic             out_strobe;
  logic             out_cell_alive;

  board_row_t  board_now [BOARD_SIDE];
  board_row_t  board_prev [BOARD_SIDE];
  logic        expected_alive_q [$];
  int          mismatch_count = 0;
  int          sent_count     = 0;
  cell_probe_t probe_table [PROBE_ROWS];

  life_board_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_row         (in_row),
    .in_column      (in_column),
    .out_strobe     (out_strobe),
    .out_cell_alive (out_cell_alive)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic prior_cell(int r, int c);
    if (r < 0 || r >= BOARD_SIDE || c < 0 || c >= BOARD_SIDE) return 1'b0;
    return board_prev[r][c];
  endfunction

  function automatic void advance_board();
    int n;
    for (int r = 0; r < BOARD_SIDE; r++) board_prev[r] = board_now[r];
    for (int r = 0; r < BOARD_SIDE; r++) begin
      for (int c = 0; c < BOARD_SIDE; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) n += int'(prior_cell(r + dr, c + dc));
          end
        end
        board_now[r][c] = (n == 3) || (board_prev[r][c] && n == 2);
      end
    end
  endfunction

  function automatic logic predict_cell_action(action_t act, logic [ROW_W-1:0] row,
                                               logic [COL_W-1:0] column);
    bit on_board;
    on_board = (int'(row) < BOARD_SIDE) && (int'(column) < BOARD_SIDE);
    case (act)
      ACT_SET:   if (on_board) board_now[row][column] = 1'b1;
      ACT_CLEAR: if (on_board) board_now[row][column] = 1'b0;
      ACT_STEP:  advance_board();
      default:   ;
    endcase
    return on_board ? board_now[row][column] : 1'b0;
  endfunction

  function automatic int pick_gap(bit idle_on);
    int roll;
    roll = int'($urandom_range(0, 99));
    if (!idle_on || roll < 55) return 0;
    if (roll < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 60));
  endfunction

  task automatic issue_action(action_t act, logic [ROW_W-1:0] row, logic [COL_W-1:0] column,
                              bit fixed, logic fixed_alive, int gap);
    logic predicted;
    in_action <= act;
    in_row    <= row;
    in_column <= column;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = predict_cell_action(act, row, column);
    expected_alive_q.push_back(fixed ? fixed_alive : predicted);
    sent_count++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    if (start) start <= 1'b0;
    while (expected_alive_q.size() != 0) @(posedge clk);
  endtask

  // check each transfer on the result side against the oldest expectation
  always @(posedge clk) begin
    logic want;
    if (rst_n && out_strobe) begin
      if (expected_alive_q.size() == 0) begin
        $error("out_cell_alive: expected none, actual %0b", out_cell_alive);
        mismatch_count++;
      end else begin
        want = expected_alive_q.pop_front();
        if (out_cell_alive !== want) begin
          $error("out_cell_alive: expected %0b, actual %0b", want, out_cell_alive);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [ROW_W-1:0] base_row;
    logic [COL_W-1:0] base_col;
    bit               idle_on;
    action_t          act;

    probe_table = '{
      '{ACT_READ,  6'd0,  6'd0,  1'b1, 1'b0},
      '{ACT_READ,  6'd63, 6'd63, 1'b1, 1'b0},
      '{ACT_SET,   6'd0,  6'd0,  1'b1, 1'b1},
      '{ACT_SET,   6'd63, 6'd63, 1'b1, 1'b1},
      '{ACT_SET,   6'd0,  6'd63, 1'b1, 1'b1},
      '{ACT_SET,   6'd63, 6'd0,  1'b1, 1'b1},
      '{ACT_CLEAR, 6'd63, 6'd0,  1'b1, 1'b0},
      '{ACT_CLEAR, 6'd63, 6'd0,  1'b1, 1'b0},
      '{ACT_STEP,  6'd0,  6'd0,  1'b1, 1'b0},
      '{ACT_READ,  6'd63, 6'd63, 1'b1, 1'b0},
      '{ACT_SET,   6'd0,  6'd0,  1'b1, 1'b1},
      '{ACT_SET,   6'd0,  6'd1,  1'b1, 1'b1},
      '{ACT_SET,   6'd1,  6'd0,  1'b1, 1'b1},
      '{ACT_STEP,  6'd1,  6'd1,  1'b0, 1'b0},
      '{ACT_READ,  6'd0,  6'd0,  1'b0, 1'b0},
      '{ACT_SET,   6'd63, 6'd30, 1'b1, 1'b1},
      '{ACT_SET,   6'd63, 6'd31, 1'b1, 1'b1},
      '{ACT_SET,   6'd63, 6'd32, 1'b1, 1'b1},
      '{ACT_STEP,  6'd62, 6'd31, 1'b0, 1'b0},
      '{ACT_STEP,  6'd63, 6'd31, 1'b0, 1'b0},
      '{ACT_SET,   6'd20, 6'd63, 1'b1, 1'b1},
      '{ACT_SET,   6'd21, 6'd63, 1'b1, 1'b1},
      '{ACT_SET,   6'd22, 6'd63, 1'b1, 1'b1},
      '{ACT_STEP,  6'd21, 6'd62, 1'b0, 1'b0},
      '{ACT_READ,  6'd42, 6'd21, 1'b1, 1'b0}
    };
    for (int r = 0; r < BOARD_SIDE; r++) board_now[r] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_table[i]) begin
      issue_action(probe_table[i].act, probe_table[i].row, probe_table[i].column,
                   probe_table[i].fixed, probe_table[i].alive, pick_gap(1'b1));
    end
    drain_results();

    while (sent_count < PROBE_ROWS + RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        // build a small pattern in one window, then advance it a few generations
        base_row = ROW_W'($urandom_range(0, 63));
        base_col = COL_W'($urandom_range(0, 63));
        repeat ($urandom_range(3, 12)) begin
          act = ($urandom_range(0, 4) == 0) ? ACT_CLEAR : ACT_SET;
          issue_action(act, base_row + ROW_W'($urandom_range(0, 5)),
                       base_col + COL_W'($urandom_range(0, 5)), 1'b0, 1'b0, pick_gap(idle_on));
        end
        repeat ($urandom_range(1, 4)) begin
          issue_action(ACT_STEP, base_row + ROW_W'($urandom_range(0, 5)),
                       base_col + COL_W'($urandom_range(0, 5)), 1'b0, 1'b0, pick_gap(idle_on));
          if ($urandom_range(0, 1) == 1) begin
            issue_action(ACT_READ, base_row + ROW_W'($urandom_range(0, 5)),
                         base_col + COL_W'($urandom_range(0, 5)), 1'b0, 1'b0,
                         pick_gap(idle_on));
          end
        end
      end else begin
        repeat ($urandom_range(4, 12)) begin
          issue_action(action_t'($urandom_range(0, 3)), ROW_W'($urandom_range(0, 63)),
                       COL_W'($urandom_range(0, 63)), 1'b0, 1'b0, pick_gap(idle_on));
        end
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (BOARD_SIDE + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
